@@ hdl/salct_pkg.sv @@
package salct_pkg;

	// Widths fixed by the transaction formats.
	localparam int ADDR_FIELD_W = 32;
	localparam int CNT_W        = 32;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_INDEX_W  = 2;

	// Action codes of an input transaction ('L', 'S' and 'M' of a trace).
	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_MODIFY = 2'd2;

	// Outcome codes of the first access.
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd2;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [4:0] block_bits;
		logic [3:0] ways;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{set_bits: 3'd0, block_bits: 5'd0, ways: 4'd1};

	typedef struct packed {
		logic [1:0]              action;
		logic [ADDR_FIELD_W-1:0] address;
	} item_t;

	typedef struct packed {
		logic [1:0]       outcome;
		logic             second_hit;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] evict_total;
	} result_t;

endpackage

@@ hdl/salct_ram.sv @@
module salct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/salct_fifo.sv @@
module salct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ hdl/salct_front.sv @@
module salct_front #(
	parameter int MAX_SET_BITS = 6,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  salct_pkg::cfg_t     cfg,
	input  logic                push,
	output logic                full,
	input  salct_pkg::item_t    item,
	output logic                ent_empty,
	input  logic                ent_pop,
	output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] ent_set,
	output logic [((ADDR_WIDTH < salct_pkg::ADDR_FIELD_W) ? ADDR_WIDTH
		: salct_pkg::ADDR_FIELD_W)-1:0] ent_tag,
	output logic                ent_mod
);

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int TAG_W = (ADDR_WIDTH < salct_pkg::ADDR_FIELD_W) ? ADDR_WIDTH
		: salct_pkg::ADDR_FIELD_W;
	localparam int ENT_W = 1 + SET_W + TAG_W;

	logic [TAG_W-1:0] addr_eff;
	logic [3:0]       sb;
	logic [SET_W:0]   one_sh;
	logic [SET_W:0]   mask_full;
	logic [TAG_W-1:0] shifted;
	logic [5:0]       tag_shamt;
	logic [SET_W-1:0] set_idx;
	logic [TAG_W-1:0] tag;
	logic             is_mod;
	logic [ENT_W-1:0] din;
	logic [ENT_W-1:0] dout;

	assign addr_eff = item.address[TAG_W-1:0];

	// The set field is clamped to the number of sets that the storage has.
	always_comb begin
		if ({1'b0, cfg.set_bits} > 4'(MAX_SET_BITS)) begin
			sb = 4'(MAX_SET_BITS);
		end else begin
			sb = {1'b0, cfg.set_bits};
		end
	end

	assign one_sh    = (SET_W + 1)'(1) << sb;
	assign mask_full = one_sh - (SET_W + 1)'(1);
	assign shifted   = addr_eff >> cfg.block_bits;
	assign set_idx   = shifted[SET_W-1:0] & mask_full[SET_W-1:0];
	assign tag_shamt = 6'(sb) + 6'(cfg.block_bits);
	assign tag       = addr_eff >> tag_shamt;
	assign is_mod    = (item.action == salct_pkg::ACT_MODIFY);
	assign din       = {is_mod, set_idx, tag};

	salct_fifo #(
		.WIDTH (ENT_W),
		.DEPTH (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.din    (din),
		.pop    (ent_pop),
		.empty  (ent_empty),
		.dout   (dout)
	);

	assign ent_mod = dout[ENT_W-1];
	assign ent_set = dout[TAG_W +: SET_W];
	assign ent_tag = dout[TAG_W-1:0];

endmodule

@@ hdl/salct_back.sv @@
module salct_back #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  salct_pkg::cfg_t     cfg,
	input  logic                ent_empty,
	output logic                ent_pop,
	input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] ent_set,
	input  logic [((ADDR_WIDTH < salct_pkg::ADDR_FIELD_W) ? ADDR_WIDTH
		: salct_pkg::ADDR_FIELD_W)-1:0] ent_tag,
	input  logic                ent_mod,
	output logic                empty,
	input  logic                pop,
	output salct_pkg::result_t  result
);

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int TAG_W = (ADDR_WIDTH < salct_pkg::ADDR_FIELD_W) ? ADDR_WIDTH
		: salct_pkg::ADDR_FIELD_W;
	localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ENT_W = TAG_W + RW + 1;
	localparam int ROW_W = MAX_WAYS * ENT_W;
	localparam int DEPTH = 1 << MAX_SET_BITS;
	localparam int RES_W = $bits(salct_pkg::result_t);
	localparam int CW    = salct_pkg::CNT_W;
	localparam logic [RW-1:0] RANK_TOP = RW'(MAX_WAYS - 1);

	typedef enum logic [1:0] {
		ST_READ = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	state_t             state_q;
	logic [SET_W-1:0]   cur_set_s1;
	logic [TAG_W-1:0]   cur_tag_s1;
	logic               cur_mod_s1;
	logic               rowv_s1;
	logic [DEPTH-1:0]   rowv_q;
	logic [CW-1:0]      hits_q;
	logic [CW-1:0]      misses_q;
	logic [CW-1:0]      evicts_q;

	logic               start;
	logic               res_full;
	logic               res_push;
	logic [ROW_W-1:0]   row_rd;
	logic [ROW_W-1:0]   row_wr;
	logic [4:0]         n_used;
	logic [MAX_WAYS-1:0] in_use;
	logic [TAG_W-1:0]   way_tag   [MAX_WAYS];
	logic [RW-1:0]      way_rank  [MAX_WAYS];
	logic [MAX_WAYS-1:0] way_valid;
	logic [TAG_W-1:0]   nxt_tag   [MAX_WAYS];
	logic [RW-1:0]      nxt_rank  [MAX_WAYS];
	logic [MAX_WAYS-1:0] nxt_valid;
	logic [MAX_WAYS-1:0] hit_vec;
	logic [MAX_WAYS-1:0] inv_vec;
	logic               hit;
	logic               has_inv;
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   fill_way;
	logic [WAY_W-1:0]   victim;
	logic [WAY_W-1:0]   sel_way;
	logic [RW-1:0]      old_rank;
	logic [CW+1:0]      hit_sum;
	logic [CW-1:0]      hits_nxt;
	logic [CW-1:0]      misses_nxt;
	logic [CW-1:0]      evicts_nxt;
	logic [1:0]         outcome;
	salct_pkg::result_t res_in;
	logic [RES_W-1:0]   res_dout;

	assign start    = (state_q == ST_READ) & ~ent_empty & ~res_full;
	assign ent_pop  = start;
	assign res_push = (state_q == ST_LOOK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_READ;
			rowv_q   <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else begin
			case (state_q)
				ST_READ: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q             <= ST_READ;
					rowv_q[cur_set_s1]  <= 1'b1;
					hits_q              <= hits_nxt;
					misses_q            <= misses_nxt;
					evicts_q            <= evicts_nxt;
				end
				default: state_q <= ST_READ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_set_s1 <= ent_set;
			cur_tag_s1 <= ent_tag;
			cur_mod_s1 <= ent_mod;
			rowv_s1    <= rowv_q[ent_set];
		end
	end

	salct_ram #(
		.WIDTH (ROW_W),
		.DEPTH (DEPTH)
	) u_rows (
		.clk   (clk),
		.we    (res_push),
		.waddr (cur_set_s1),
		.wdata (row_wr),
		.re    (start),
		.raddr (ent_set),
		.rdata (row_rd)
	);

	// Ways beyond the configured count are left untouched.
	always_comb begin
		if (cfg.ways == '0) begin
			n_used = 5'd1;
		end else if ({1'b0, cfg.ways} > 5'(MAX_WAYS)) begin
			n_used = 5'(MAX_WAYS);
		end else begin
			n_used = {1'b0, cfg.ways};
		end
	end

	// A row never written since reset reads as all lines invalid with rank zero.
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			way_valid[w] = rowv_s1 & row_rd[w*ENT_W];
			way_rank[w]  = rowv_s1 ? row_rd[w*ENT_W + 1 +: RW] : '0;
			way_tag[w]   = row_rd[w*ENT_W + 1 + RW +: TAG_W];
			in_use[w]    = (5'(w) < n_used);
			hit_vec[w]   = in_use[w] & way_valid[w] & (way_tag[w] == cur_tag_s1);
			inv_vec[w]   = in_use[w] & ~way_valid[w];
		end
	end

	assign hit     = |hit_vec;
	assign has_inv = |inv_vec;

	always_comb begin
		hit_way  = '0;
		fill_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
			if (inv_vec[w]) begin
				fill_way = WAY_W'(w);
			end
		end
	end

	// Oldest line wins; a strict compare keeps the lowest way on a tie.
	always_comb begin
		victim = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && (way_rank[w] > way_rank[victim])) begin
				victim = WAY_W'(w);
			end
		end
	end

	assign old_rank = way_rank[hit_way];

	always_comb begin
		if (hit) begin
			sel_way = hit_way;
			outcome = salct_pkg::OUT_HIT;
		end else if (has_inv) begin
			sel_way = fill_way;
			outcome = salct_pkg::OUT_FILL;
		end else begin
			sel_way = victim;
			outcome = salct_pkg::OUT_EVICT;
		end
	end

	// The touched line becomes rank zero. On a hit only the lines that were more
	// recent than it age; on a miss every valid in-use line ages, up to RANK_TOP.
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			nxt_tag[w]   = way_tag[w];
			nxt_rank[w]  = way_rank[w];
			nxt_valid[w] = way_valid[w];
			if (WAY_W'(w) == sel_way) begin
				nxt_valid[w] = 1'b1;
				nxt_rank[w]  = '0;
				if (!hit) begin
					nxt_tag[w] = cur_tag_s1;
				end
			end else if (in_use[w] && way_valid[w] && (!hit || (way_rank[w] < old_rank))
				&& (way_rank[w] < RANK_TOP)) begin
				nxt_rank[w] = way_rank[w] + RW'(1);
			end
			row_wr[w*ENT_W +: ENT_W] = {nxt_tag[w], nxt_rank[w], nxt_valid[w]};
		end
	end

	// The second access of a modify always hits and leaves the ranks as they are.
	assign hit_sum  = (CW + 2)'(hits_q) + (CW + 2)'(hit) + (CW + 2)'(cur_mod_s1);
	assign hits_nxt = (hit_sum > (CW + 2)'({CW{1'b1}})) ? {CW{1'b1}} : hit_sum[CW-1:0];
	assign misses_nxt = (!hit && (misses_q != {CW{1'b1}})) ? misses_q + CW'(1) : misses_q;
	assign evicts_nxt = (!hit && !has_inv && (evicts_q != {CW{1'b1}}))
		? evicts_q + CW'(1) : evicts_q;

	always_comb begin
		res_in.outcome     = outcome;
		res_in.second_hit  = cur_mod_s1;
		res_in.hit_total   = hits_nxt;
		res_in.miss_total  = misses_nxt;
		res_in.evict_total = evicts_nxt;
	end

	salct_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_results (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_dout)
	);

	assign result = salct_pkg::result_t'(res_dout);

	a_room_for_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !res_full)
		else $error("result queue full while a lookup completes");

	a_read_then_look: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_LOOK))
		else $error("row read not followed by its update");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hits_q >= $past(hits_q)))
		else $error("hit count went down");

	a_evict_le_miss: assert property (@(posedge clk) disable iff (!arst_n)
		evicts_q <= misses_q)
		else $error("more evictions than misses");

endmodule

@@ hdl/set_assoc_lru_cache_tracker.sv @@
// Set-associative cache tracker with LRU replacement, tags only.
// Input side is a queue: drive item (action, address) and raise push; the
// transaction is taken on a clock edge where push is high and full is low.
// Result side is a queue too: while empty is low the oldest result (outcome,
// second_hit and the running hit, miss and eviction totals) is on result,
// and it is taken on a clock edge where pop is high.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while no transaction is in flight.
// A taken transaction waits in the front queue until the lookup engine is in
// ST_READ and the result queue has room. ST_READ reads the row from the
// single set-row memory; ST_LOOK compares all ways, updates ranks, writes
// the row back and queues the result; no new lookup starts during ST_LOOK.
// A front queue of two entries takes input while the lookup engine works; a
// result queue of two entries lets input continue while the receiver stalls.
// When both queues fill, full rises until results are popped.
// Reset clears the counters, the configuration (set_bits 0, block_bits 0,
// ways 1) and one valid flag per set row, so all lines read invalid at once;
// no clearing pass is needed and the block takes input right after reset.
module set_assoc_lru_cache_tracker #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  salct_pkg::item_t                       item,
	output logic                                   empty,
	input  logic                                   pop,
	output salct_pkg::result_t                     result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [salct_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [salct_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int TAG_W = (ADDR_WIDTH < salct_pkg::ADDR_FIELD_W) ? ADDR_WIDTH
		: salct_pkg::ADDR_FIELD_W;

	salct_pkg::cfg_t  cfg_q;
	logic             ent_empty;
	logic             ent_pop;
	logic [SET_W-1:0] ent_set;
	logic [TAG_W-1:0] ent_tag;
	logic             ent_mod;

	// Registers are always writable; an index past the last register is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= salct_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				salct_pkg::CFG_SET_BITS:   cfg_q.set_bits   <= cfg_data[2:0];
				salct_pkg::CFG_BLOCK_BITS: cfg_q.block_bits <= cfg_data[4:0];
				salct_pkg::CFG_WAYS:       cfg_q.ways       <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: splits each address into set index and tag and queues the access.
	salct_front #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.item      (item),
		.ent_empty (ent_empty),
		.ent_pop   (ent_pop),
		.ent_set   (ent_set),
		.ent_tag   (ent_tag),
		.ent_mod   (ent_mod)
	);

	// Back: reads the set row, resolves hit, fill or eviction, updates the
	// LRU ranks and the totals, and queues the result.
	salct_back #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ent_empty (ent_empty),
		.ent_pop   (ent_pop),
		.ent_set   (ent_set),
		.ent_tag   (ent_tag),
		.ent_mod   (ent_mod),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ bench/set_assoc_lru_cache_tracker_test.sv @@
`timescale 1ns / 1ps

module set_assoc_lru_cache_tracker_test;

	// Geometry of the tracked cache, matching the block's default parameters.
	localparam int NUM_SETS = 64;
	localparam int MAX_SET  = 6;
	localparam int MAX_WAY  = 8;

	// Register index past the end of the register list; a write there is dropped.
	localparam logic [salct_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
	// Action code with no meaning of its own; the block treats it as a load.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int IDLE_LIMIT    = 3000;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_ITEMS   = 120;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              push      = 1'b0;
	logic                              full;
	salct_pkg::item_t                  item_bus  = '0;
	logic                              empty;
	logic                              pop       = 1'b0;
	salct_pkg::result_t                result_bus;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [salct_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [salct_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	set_assoc_lru_cache_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item_bus),
		.empty     (empty),
		.pop       (pop),
		.result    (result_bus),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the configuration registers, updated when a write is taken.
	logic [2:0] shadow_set_bits   = 3'd0;
	logic [4:0] shadow_block_bits = 5'd0;
	logic [3:0] shadow_ways       = 4'd1;

	// Our own copy of the tag array. Rank 0 is the most recent line of a set.
	logic [31:0] tag_store   [NUM_SETS][MAX_WAY];
	logic        valid_store [NUM_SETS][MAX_WAY];
	logic [2:0]  rank_store  [NUM_SETS][MAX_WAY];
	logic [31:0] exp_hits    = '0;
	logic [31:0] exp_misses  = '0;
	logic [31:0] exp_evicts  = '0;

	salct_pkg::item_t   pending_items[$];
	salct_pkg::result_t expected_results[$];

	int failures     = 0;
	int results_seen = 0;
	int idle_cycles  = 0;

	function automatic logic [31:0] sat_inc(logic [31:0] count);
		return (count == '1) ? count : count + 32'd1;
	endfunction

	// Make a way the most recent of its set. Every other valid line that was
	// younger than the old rank of this way gets one step older, up to the
	// oldest rank. A freshly filled line passes an old rank above all others.
	function automatic void promote_line(int set_idx, int way, int n_ways, int old_rank);
		for (int j = 0; j < n_ways; j++) begin
			if (j != way && valid_store[set_idx][j] && rank_store[set_idx][j] < old_rank &&
			    rank_store[set_idx][j] < MAX_WAY - 1)
				rank_store[set_idx][j]++;
		end
		rank_store[set_idx][way] = 3'd0;
	endfunction

	// One access to the tracked cache at a byte address.
	function automatic logic [1:0] cache_access(logic [31:0] addr);
		int          n_ways;
		int          sb;
		int          bb;
		int          set_idx;
		int          victim;
		logic [63:0] wide;
		logic [31:0] line;

		// Out-of-range settings are clamped rather than rejected.
		n_ways = (shadow_ways == 0) ? 1 : (shadow_ways > MAX_WAY) ? MAX_WAY : int'(shadow_ways);
		sb = (shadow_set_bits > MAX_SET) ? MAX_SET : int'(shadow_set_bits);
		bb = shadow_block_bits;
		// Shifts at or past the address width leave nothing, so the tag is zero.
		wide = {32'd0, addr};
		set_idx = int'((wide >> bb) & ((64'd1 << sb) - 64'd1));
		line = 32'(wide >> (sb + bb));

		// Ways above the current associativity are neither searched nor touched.
		for (int j = 0; j < n_ways; j++) begin
			if (valid_store[set_idx][j] && tag_store[set_idx][j] == line) begin
				exp_hits = sat_inc(exp_hits);
				promote_line(set_idx, j, n_ways, rank_store[set_idx][j]);
				return salct_pkg::OUT_HIT;
			end
		end
		exp_misses = sat_inc(exp_misses);
		for (int j = 0; j < n_ways; j++) begin
			if (!valid_store[set_idx][j]) begin
				valid_store[set_idx][j] = 1'b1;
				tag_store[set_idx][j] = line;
				promote_line(set_idx, j, n_ways, 255);
				return salct_pkg::OUT_FILL;
			end
		end
		// Set is full: the oldest way goes, and the lowest index wins a tie.
		exp_evicts = sat_inc(exp_evicts);
		victim = 0;
		for (int j = 1; j < n_ways; j++) begin
			if (rank_store[set_idx][j] > rank_store[set_idx][victim])
				victim = j;
		end
		tag_store[set_idx][victim] = line;
		promote_line(set_idx, victim, n_ways, 255);
		return salct_pkg::OUT_EVICT;
	endfunction

	// Expected result of one transaction. A modify is a read followed by a
	// write to the same line, and the write always hits.
	function automatic salct_pkg::result_t predict_result(salct_pkg::item_t it);
		salct_pkg::result_t r;

		r.outcome = cache_access(it.address);
		r.second_hit = 1'b0;
		if (it.action == salct_pkg::ACT_MODIFY) begin
			void'(cache_access(it.address));
			r.second_hit = 1'b1;
		end
		r.hit_total = exp_hits;
		r.miss_total = exp_misses;
		r.evict_total = exp_evicts;
		return r;
	endfunction

	// Wait before the next transaction on one side. Each side runs in stretches,
	// each either with no idling or with random gaps.
	function automatic int next_wait(inout int run_left, inout bit eager);
		if (run_left == 0) begin
			eager = ($urandom_range(0, 2) == 0);
			run_left = $urandom_range(20, 60);
		end
		run_left--;
		return eager ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic compare_result(salct_pkg::result_t want, salct_pkg::result_t got);
		if (got.outcome !== want.outcome) begin
			$error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
			failures++;
		end
		if (got.second_hit !== want.second_hit) begin
			$error("second_hit: expected %0d, got %0d", want.second_hit, got.second_hit);
			failures++;
		end
		if (got.hit_total !== want.hit_total) begin
			$error("hit_total: expected %0d, got %0d", want.hit_total, got.hit_total);
			failures++;
		end
		if (got.miss_total !== want.miss_total) begin
			$error("miss_total: expected %0d, got %0d", want.miss_total, got.miss_total);
			failures++;
		end
		if (got.evict_total !== want.evict_total) begin
			$error("evict_total: expected %0d, got %0d", want.evict_total, got.evict_total);
			failures++;
		end
	endtask

	// Sender. A transaction is taken at an edge where push is high and full is
	// low; the prediction is made right then, in the order the block sees them.
	// Signals read here hold their values from before the edge, since every
	// update made at the edge is nonblocking.
	int send_wait = 0;
	int send_run  = 0;
	bit send_eager = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				expected_results.push_back(predict_result(item_bus));
				send_wait = next_wait(send_run, send_eager);
			end
			// A transaction that is not yet taken stays on the bus unchanged.
			if (!push || !full) begin
				if (send_wait > 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item_bus <= pending_items.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each result taken is checked against the oldest prediction.
	// Once, it holds pop low for a long stretch while the sender keeps going,
	// so both internal queues fill and full has to rise.
	int recv_wait = 0;
	int recv_run  = 0;
	bit recv_eager = 1'b0;
	int hold_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with no transaction outstanding: outcome %0d",
					       result_bus.outcome);
					failures++;
				end else begin
					compare_result(expected_results.pop_front(), result_bus);
				end
				recv_wait = next_wait(recv_run, recv_eager);
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: any transaction on any port restarts the count.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("set_assoc_lru_cache_tracker: mismatch");
			$finish;
		end
	end

	// Called at a rising edge. The shadow copy changes at the edge where the
	// write is taken. cfg_valid is left high so back-to-back writes need only
	// one assignment per edge; the caller lowers it after the last one.
	task automatic write_reg(logic [salct_pkg::CFG_INDEX_W-1:0] idx,
	                         logic [salct_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			salct_pkg::CFG_SET_BITS:   shadow_set_bits = data[2:0];
			salct_pkg::CFG_BLOCK_BITS: shadow_block_bits = data;
			salct_pkg::CFG_WAYS:       shadow_ways = data[3:0];
			default: ;
		endcase
	endtask

	// Writes every register, plus a dropped write past the end of the list.
	// Only called while nothing is in flight. Returns on a falling edge so the
	// caller can fill the queue of pending items without racing the sender.
	task automatic configure(logic [4:0] sb_data, logic [4:0] bb_data, logic [4:0] wy_data);
		@(posedge clk);
		write_reg(salct_pkg::CFG_SET_BITS, sb_data);
		write_reg(salct_pkg::CFG_BLOCK_BITS, bb_data);
		write_reg(salct_pkg::CFG_WAYS, wy_data);
		write_reg(CFG_UNMAPPED, 5'($urandom_range(0, 31)));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_item(logic [1:0] action, logic [31:0] address);
		salct_pkg::item_t it;

		it.action = action;
		it.address = address;
		pending_items.push_back(it);
	endtask

	// Idle means every pending item was taken and every result came back.
	// Checked on the falling edge, after everything done at the rising edge.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || push || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [4:0]  sb_data;
		logic [4:0]  bb_data;
		logic [4:0]  wy_data;
		logic [31:0] tag_pool [16];
		logic [5:0]  set_pool [4];
		int          n_tags;
		int          sbe;
		int          bbe;
		logic [63:0] wide;

		for (int s = 0; s < NUM_SETS; s++) begin
			for (int w = 0; w < MAX_WAY; w++) begin
				tag_store[s][w] = '0;
				valid_store[s][w] = 1'b0;
				rank_store[s][w] = '0;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Four sets, 16-byte lines, two ways: fills, hits, evictions in the
		// order of age, the modify's second access, the unused action code and
		// the extreme addresses.
		configure(5'd2, 5'd4, 5'd2);
		add_item(salct_pkg::ACT_LOAD, 32'h0000_0000);
		add_item(salct_pkg::ACT_STORE, 32'h0000_000F);
		add_item(salct_pkg::ACT_MODIFY, 32'h0000_0040);
		add_item(salct_pkg::ACT_LOAD, 32'h0000_0080);
		add_item(ACT_UNUSED, 32'h0000_0000);
		add_item(salct_pkg::ACT_LOAD, 32'hFFFF_FFFF);
		add_item(salct_pkg::ACT_STORE, 32'h8000_0000);
		add_item(salct_pkg::ACT_MODIFY, 32'h7FFF_FFFF);
		add_item(salct_pkg::ACT_LOAD, 32'h5555_5555);
		add_item(salct_pkg::ACT_STORE, 32'hAAAA_AAAA);
		add_item(salct_pkg::ACT_MODIFY, 32'hFFFF_FFFF);
		wait_idle();

		// set_bits above the maximum, block_bits at its top and ways of zero:
		// the tag is always zero and only address bit 31 picks the set.
		configure(5'd7, 5'd31, 5'd0);
		add_item(salct_pkg::ACT_LOAD, 32'h0000_0000);
		add_item(salct_pkg::ACT_LOAD, 32'h8000_0000);
		add_item(salct_pkg::ACT_MODIFY, 32'h7FFF_FFFF);
		add_item(ACT_UNUSED, 32'hFFFF_FFFF);
		wait_idle();

		// Set and block bits that add up to exactly the address width, and
		// ways above the maximum.
		configure(5'd6, 5'd26, 5'd15);
		add_item(salct_pkg::ACT_LOAD, 32'hFC00_0000);
		add_item(salct_pkg::ACT_LOAD, 32'h0400_0000);
		add_item(salct_pkg::ACT_STORE, 32'hFFFF_FFFF);
		wait_idle();

		// Random phases. The first few use fixed settings: eight ways, then two
		// over the same lines, then eight again, so that lines outside the
		// reduced range are kept and come back; after that come the reset
		// values, the widest set index and the extremes of block_bits.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: {sb_data, bb_data, wy_data} = {5'd3, 5'd4, 5'd8};
				1: {sb_data, bb_data, wy_data} = {5'd3, 5'd4, 5'd2};
				2: {sb_data, bb_data, wy_data} = {5'd3, 5'd4, 5'd8};
				3: {sb_data, bb_data, wy_data} = {5'd0, 5'd0, 5'd1};
				4: {sb_data, bb_data, wy_data} = {5'd6, 5'd0, 5'd24};
				5: {sb_data, bb_data, wy_data} = {5'd0, 5'd31, 5'd16};
				6: {sb_data, bb_data, wy_data} = {5'd5, 5'd2, 5'd3};
				default: begin
					sb_data = 5'($urandom_range(0, 31));
					bb_data = 5'($urandom_range(0, 31));
					wy_data = 5'($urandom_range(0, 31));
				end
			endcase
			configure(sb_data, bb_data, wy_data);

			// Most addresses come from a small working set of tags and sets, so
			// lines are reused and sets overflow; one in ten is a fully random
			// address.
			sbe = (shadow_set_bits > MAX_SET) ? MAX_SET : int'(shadow_set_bits);
			bbe = shadow_block_bits;
			n_tags = $urandom_range(1, 12);
			for (int k = 0; k < 16; k++)
				tag_pool[k] = $urandom;
			for (int k = 0; k < 4; k++)
				set_pool[k] = 6'($urandom_range(0, NUM_SETS - 1));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					wide = {32'd0, $urandom};
				end else begin
					wide = {32'd0, tag_pool[$urandom_range(0, n_tags - 1)]} << (sbe + bbe);
					wide |= ({58'd0, set_pool[$urandom_range(0, 3)]} &
					         ((64'd1 << sbe) - 64'd1)) << bbe;
					wide |= {$urandom, $urandom} & ((64'd1 << bbe) - 64'd1);
				end
				add_item(2'($urandom_range(0, 3)), wide[31:0]);
			end
			wait_idle();
		end

		if (failures == 0)
			$display("set_assoc_lru_cache_tracker: match");
		else
			$display("set_assoc_lru_cache_tracker: mismatch");
		$finish;
	end

endmodule
